### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/shc_pkg.sv
// Shared types, constants and round functions of the SHA-256 core.
package shc_pkg;

	// Byte source for the block packer
	typedef enum logic [1:0] {
		SRC_DATA = 2'd0,
		SRC_PAD  = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN  = 2'd3
	} src_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       capture;
		logic       push;
		src_t       src;
		logic [1:0] data_pos;
		logic [2:0] len_idx;
		logic [5:0] fill;
		logic       count_bits;
		logic       load_work;
		logic       round;
		logic [5:0] round_idx;
		logic       update;
		logic       out_load;
		logic [2:0] out_idx;
		logic       restore;
	} cmd_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

### sv/shc_ctrl.sv
// Controller of the SHA-256 core: byte packing, padding, rounds and digest output.
module shc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [2:0]    byte_count,
	input  logic          last,
	output logic          out_valid,
	input  logic          out_stall,
	output shc_pkg::cmd_t cmd
);
	import shc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PUSH   = 5'b00010,
		ST_ROUND  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_OUTPUT = 5'b10000
	} state_t;

	typedef enum logic [5:0] {
		PH_DATA   = 6'b000001,
		PH_PAD80  = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_LEN    = 6'b001000,
		PH_DONE   = 6'b010000,
		PH_DIGEST = 6'b100000
	} phase_t;

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d, ph_next;
	logic [2:0] rem_q, rem_d;
	logic [1:0] pos_q, pos_d;
	logic       last_q, last_d;
	logic [2:0] len_q, len_d;
	logic [5:0] fill_q, fill_d;
	logic [5:0] rnd_q, rnd_d;
	logic [2:0] oidx_q, oidx_d;
	logic       ovalid_q, ovalid_d;
	logic [2:0] cnt_sat;

	// Saturate the byte count at four
	assign cnt_sat  = (byte_count > 3'd4) ? 3'd4 : byte_count;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = ovalid_q;

	// Sequence the item through packing, rounds and output
	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		ph_next  = phase_q;
		rem_d    = rem_q;
		pos_d    = pos_q;
		last_d   = last_q;
		len_d    = len_q;
		fill_d   = fill_q;
		rnd_d    = rnd_q;
		oidx_d   = oidx_q;
		ovalid_d = ovalid_q && out_stall;

		cmd           = '0;
		cmd.data_pos  = pos_q;
		cmd.len_idx   = len_q;
		cmd.fill      = fill_q;
		cmd.round_idx = rnd_q;
		cmd.out_idx   = oidx_q;

		case (phase_q)
			PH_DATA:  cmd.src = SRC_DATA;
			PH_PAD80: cmd.src = SRC_PAD;
			PH_LEN:   cmd.src = SRC_LEN;
			default:  cmd.src = SRC_ZERO;
		endcase

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					rem_d  = cnt_sat;
					pos_d  = 2'd0;
					last_d = last;
					len_d  = 3'd7;
					if (cnt_sat != 3'd0) begin
						phase_d = PH_DATA;
						state_d = ST_PUSH;
					end else if (last) begin
						phase_d = PH_PAD80;
						state_d = ST_PUSH;
					end
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				fill_d   = fill_q + 6'd1;
				case (phase_q)
					PH_DATA: begin
						cmd.count_bits = 1'b1;
						rem_d = rem_q - 3'd1;
						pos_d = pos_q + 2'd1;
						if (rem_q == 3'd1) begin
							ph_next = last_q ? PH_PAD80 : PH_DONE;
						end
					end
					PH_PAD80, PH_ZERO: begin
						ph_next = (fill_q == 6'd55) ? PH_LEN : PH_ZERO;
					end
					PH_LEN: begin
						len_d = len_q - 3'd1;
						if (len_q == 3'd0) begin
							ph_next = PH_DIGEST;
						end
					end
					default: ph_next = PH_DONE;
				endcase
				phase_d = ph_next;
				// A full block starts the compression
				if (fill_q == 6'd63) begin
					cmd.load_work = 1'b1;
					rnd_d   = 6'd0;
					state_d = ST_ROUND;
				end else if (ph_next == PH_DONE) begin
					state_d = ST_IDLE;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				rnd_d = rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				if (phase_q == PH_DONE) begin
					state_d = ST_IDLE;
				end else if (phase_q == PH_DIGEST) begin
					oidx_d  = 3'd0;
					state_d = ST_OUTPUT;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_OUTPUT: begin
				// Load the next digest word once the output register is free
				if (!ovalid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					ovalid_d = 1'b1;
					oidx_d   = oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						cmd.restore = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold the control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_DONE;
			rem_q    <= 3'd0;
			pos_q    <= 2'd0;
			last_q   <= 1'b0;
			len_q    <= 3'd0;
			fill_q   <= 6'd0;
			rnd_q    <= 6'd0;
			oidx_q   <= 3'd0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			rem_q    <= rem_d;
			pos_q    <= pos_d;
			last_q   <= last_d;
			len_q    <= len_d;
			fill_q   <= fill_d;
			rnd_q    <= rnd_d;
			oidx_q   <= oidx_d;
			ovalid_q <= ovalid_d;
		end
	end

endmodule

### sv/shc_datapath.sv
// Datapath of the SHA-256 core: block buffer, round logic, chaining hash and output register.
module shc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   message_word,
	input  shc_pkg::cmd_t cmd,
	output logic [31:0]   digest_word,
	output logic [2:0]    word_index,
	output logic          final_word
);
	import shc_pkg::*;

	logic [31:0] word_q;
	logic [63:0] bits_q;
	logic [31:0] win_q   [16];
	logic [31:0] work_q  [8];
	logic [31:0] chain_q [8];
	logic [31:0] dout_q;
	logic [2:0]  widx_q;
	logic        fin_q;

	logic [7:0]  byte_w;
	logic [31:0] w_new;
	logic [31:0] ch_w;
	logic [31:0] maj_w;
	logic [31:0] t1_w;
	logic [31:0] t2_w;

	// Pick the byte to pack
	always_comb begin
		case (cmd.src)
			SRC_DATA: byte_w = word_q[{~cmd.data_pos, 3'b000} +: 8];
			SRC_PAD:  byte_w = PAD_BYTE;
			SRC_LEN:  byte_w = bits_q[{cmd.len_idx, 3'b000} +: 8];
			default:  byte_w = 8'h00;
		endcase
	end

	// Round function and schedule extension over the sliding window
	always_comb begin
		w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
		ch_w  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		maj_w = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1_w  = work_q[7] + big_sigma1(work_q[4]) + ch_w + ROUND_K[cmd.round_idx] + win_q[0];
		t2_w  = big_sigma0(work_q[0]) + maj_w;
	end

	// Capture the item word, pack bytes, run the rounds and load the output register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q <= message_word;
		end
		if (cmd.push) begin
			win_q[cmd.fill[5:2]][{~cmd.fill[1:0], 3'b000} +: 8] <= byte_w;
		end
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_new;
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1_w;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1_w + t2_w;
		end
		if (cmd.load_work) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end
		if (cmd.out_load) begin
			dout_q <= chain_q[cmd.out_idx];
			widx_q <= cmd.out_idx;
			fin_q  <= &cmd.out_idx;
		end
	end

	// Count message bits, fold the block into the chaining hash and restore both after the digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= 64'd0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_HASH[i];
			end
		end else begin
			if (cmd.restore) begin
				bits_q <= 64'd0;
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= INIT_HASH[i];
				end
			end else begin
				if (cmd.count_bits) begin
					bits_q <= bits_q + 64'd8;
				end
				if (cmd.update) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
				end
			end
		end
	end

	assign digest_word = dout_q;
	assign word_index  = widx_q;
	assign final_word  = fin_q;

endmodule

### sv/sha256_hash_core_unit.sv
// Top level of the streaming SHA-256 core.
// Message bytes are packed into the block buffer one byte per cycle, except while
// a block is compressed, after the item is taken in the idle state; the input is
// stalled until all bytes of the item are packed. Each 64-byte block then runs one
// round per cycle through the shared round logic, 64 rounds and then a fold into
// the chaining hash, during which no item is taken. An item with a zero byte count
// and no last flag is taken and dropped without stalling the input.
// The last item is followed by padding at one byte per cycle up to the end of
// the block (one extra block when fewer than nine bytes remain), its
// compression, and eight digest words, word 0 most significant, one per cycle
// while the output is not stalled. The eighth word waits in the output
// register while the next message is taken.
module sha256_hash_core_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] message_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        final_word
);
	import shc_pkg::*;

	cmd_t cmd;

	// Sequence the work
	shc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_count (byte_count),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd)
	);

	// Hash the data
	shc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.message_word (message_word),
		.cmd          (cmd),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.final_word   (final_word)
	);

endmodule

### sv/shc_checker.sv
// Port-level checker of the SHA-256 core and its bind to the top level.
`include "assert_macros.svh"

module shc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  byte_count,
	input logic        last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        final_word
);

	// A stalled digest word holds
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(digest_word) && $stable(word_index) && $stable(final_word), "stalled digest word changed")

	// The final flag marks exactly the eighth word
	`CHK_IMPL(a_final_idx, clk, arst_n, out_valid, final_word == (word_index == 3'd7), "final flag and word index disagree")

	// No item is taken while the digest is still being emitted
	`CHK_IMPL(a_busy_digest, clk, arst_n, out_valid && !final_word, in_stall, "input open during digest output")

	// An empty item without last is dropped at once
	`CHK_NEXT(a_drop_empty, clk, arst_n, in_valid && !in_stall && byte_count == 3'd0 && !last, !in_stall, "empty item not dropped")

endmodule

bind sha256_hash_core_unit shc_checker u_shc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.byte_count  (byte_count),
	.last        (last),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.digest_word (digest_word),
	.word_index  (word_index),
	.final_word  (final_word)
);

### tb/sha_digest_check_pkg.sv
// Digest predictor and result scoreboard for the SHA-256 core testbench.
package sha_digest_check_pkg;

	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam int         MAX_COUNT  = 4;
	localparam int         LEN_OFFSET = 56;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last_word;
	} digest_item_t;

	class sha_digest_board;
		logic [31:0]  chain [8];
		logic [7:0]   block_bytes [64];
		int unsigned  fill;
		logic [63:0]  bit_total;
		digest_item_t expected_digest [$];
		int unsigned  mismatches;

		function new();
			mismatches = 0;
			restart_message();
		endfunction

		// Return to the start of a fresh message
		function void restart_message();
			for (int i = 0; i < 8; i++)
				chain[i] = START_HASH[i];
			fill = 0;
			bit_total = '0;
		endfunction

		function logic [31:0] rot_right(input logic [31:0] v, input int s);
			return (v >> s) | (v << (32 - s));
		endfunction

		function logic [31:0] upper_sigma0(input logic [31:0] v);
			return rot_right(v, 2) ^ rot_right(v, 13) ^ rot_right(v, 22);
		endfunction

		function logic [31:0] upper_sigma1(input logic [31:0] v);
			return rot_right(v, 6) ^ rot_right(v, 11) ^ rot_right(v, 25);
		endfunction

		function logic [31:0] lower_sigma0(input logic [31:0] v);
			return rot_right(v, 7) ^ rot_right(v, 18) ^ (v >> 3);
		endfunction

		function logic [31:0] lower_sigma1(input logic [31:0] v);
			return rot_right(v, 17) ^ rot_right(v, 19) ^ (v >> 10);
		endfunction

		// Compress the full 64-byte block into the chaining hash
		function void fold_block();
			logic [31:0] sched [64];
			logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
			int r;
			for (r = 0; r < 16; r++)
				sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
					block_bytes[4*r+2], block_bytes[4*r+3]};
			for (r = 16; r < 64; r++)
				sched[r] = lower_sigma1(sched[r-2]) + sched[r-7] +
					lower_sigma0(sched[r-15]) + sched[r-16];
			va = chain[0]; vb = chain[1]; vc = chain[2]; vd = chain[3];
			ve = chain[4]; vf = chain[5]; vg = chain[6]; vh = chain[7];
			for (r = 0; r < 64; r++) begin
				t1 = vh + upper_sigma1(ve) + ((ve & vf) ^ (~ve & vg)) +
					ROUND_CONST[r] + sched[r];
				t2 = upper_sigma0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));
				vh = vg; vg = vf; vf = ve; ve = vd + t1;
				vd = vc; vc = vb; vb = va; va = t1 + t2;
			end
			chain[0] += va; chain[1] += vb; chain[2] += vc; chain[3] += vd;
			chain[4] += ve; chain[5] += vf; chain[6] += vg; chain[7] += vh;
		endfunction

		function void take_byte(input logic [7:0] b);
			block_bytes[fill] = b;
			fill++;
			if (fill == 64) begin
				fold_block();
				fill = 0;
			end
		endfunction

		// Absorb one accepted input item; on the last item queue the eight digest words
		function void note_message_word(input logic [31:0] w, input logic [2:0] cnt,
			input logic is_last);
			int n;
			logic [63:0] len;
			n = (cnt > MAX_COUNT) ? MAX_COUNT : int'(cnt);
			for (int i = 0; i < n; i++) begin
				take_byte(8'(w >> (24 - 8 * i)));
				bit_total += 64'd8;
			end
			if (!is_last)
				return;
			len = bit_total;
			take_byte(PAD_MARK);
			while (fill != LEN_OFFSET)
				take_byte(8'h00);
			for (int s = 7; s >= 0; s--)
				take_byte(len[8*s +: 8]);
			for (int i = 0; i < 8; i++)
				expected_digest.push_back('{word: chain[i], index: 3'(i),
					last_word: (i == 7)});
			restart_message();
		endfunction

		task report_mismatch(input string msg);
			$display("digest mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		// Compare one accepted digest word with the oldest expectation
		task check_digest_word(input logic [31:0] w, input logic [2:0] idx, input logic fin);
			digest_item_t want;
			if (expected_digest.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h index %0d final %b", w, idx, fin));
				return;
			end
			want = expected_digest.pop_front();
			if (w !== want.word || idx !== want.index || fin !== want.last_word)
				report_mismatch($sformatf("got %h/%0d/%b want %h/%0d/%b",
					w, idx, fin, want.word, want.index, want.last_word));
		endtask
	endclass

endpackage

### tb/tb.sv
// Testbench top: drives message words into the SHA-256 core and checks the digests.
module tb;
	import sha_digest_check_pkg::*;

	localparam int PHASE_ITEMS = 145;
	localparam int TAIL_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] message_word;
	logic [2:0]  byte_count;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned items_sent;
	sha_digest_board board;

	sha256_hash_core_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.message_word (message_word),
		.byte_count   (byte_count),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.final_word   (final_word)
	);

	always #5 clk = ~clk;

	// Stall the digest output at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Check every digest word taken from the output
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_digest_word(digest_word, word_index, final_word);
	end

	// Offer one item after a random gap and hold it until taken
	task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic is_last);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		message_word <= w;
		byte_count   <= cnt;
		last         <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_message_word(w, cnt, is_last);
		if (cnt != 3'd0 || is_last)
			items_sent++;
	endtask

	// Hold the input idle until every expected digest word has come out
	task automatic drain_digests();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_digest.size() != 0)
			@(negedge clk);
	endtask

	// Mostly full words, now and then short, oversized or dropped empty words
	task automatic send_random_message();
		int unsigned words;
		logic [2:0]  cnt;
		words = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 48) : $urandom_range(0, 20);
		for (int k = 0; k < words; k++) begin
			cnt = ($urandom_range(0, 99) < 70) ? 3'd4 : 3'($urandom_range(0, 7));
			send_word($urandom, cnt, 1'b0);
		end
		send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
	endtask

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		board          = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		message_word   = '0;
		byte_count     = '0;
		last           = 1'b0;
		items_sent     = 0;
		send_idle_pct  = 37;
		recv_stall_pct = 87;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty message: padding and length only
		send_word(32'h0000_0000, 3'd0, 1'b1);
		// Three bytes with junk in the unused low byte
		send_word(32'h6162_63ff, 3'd3, 1'b1);
		// Dropped empty word, then a count above four that saturates
		send_word(32'hdead_beef, 3'd0, 1'b0);
		send_word(32'h1234_5678, 3'd7, 1'b1);
		// All-zero and all-one words
		send_word(32'h0000_0000, 3'd4, 1'b0);
		send_word(32'hffff_ffff, 3'd5, 1'b1);
		// 56 bytes: the length no longer fits, so padding spills into a second block
		for (int k = 0; k < 13; k++)
			send_word($urandom, 3'd4, 1'b0);
		send_word($urandom, 3'd4, 1'b1);
		drain_digests();

		while (items_sent < 20 + PHASE_ITEMS)
			send_random_message();
		drain_digests();

		send_idle_pct  = 87;
		recv_stall_pct = 37;
		while (items_sent < 20 + 2 * PHASE_ITEMS)
			send_random_message();
		drain_digests();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (items_sent < 20 + 3 * PHASE_ITEMS)
			send_random_message();
		drain_digests();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.expected_digest.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
